>>> design/afrpm_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and types of the audio frame RMS and peak level meter.
package afrpm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_W     = 16;
  localparam int SUM_BITS    = 42;
  localparam int ROOT_W      = SUM_BITS / 2;
  localparam int SQ_REM_W    = ROOT_W + 3;
  localparam int STEP_W      = $clog2(SUM_BITS);
  localparam int CH_IDX_W    = 3;
  localparam int CC_W        = 4;
  localparam int LEN_W       = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;

  localparam int DEF_MAX_CHANNELS      = 8;
  localparam int DEF_MAX_FRAME_SAMPLES = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH  = CFG_IDX_W'(1);

  localparam logic [CC_W-1:0]    CC_RESET  = CC_W'(2);
  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(1152);
  localparam logic [LEVEL_W-1:0] START_MAX = LEVEL_W'(1 << (SAMPLE_BITS - 3));

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [LEVEL_W-1:0]            level_t;
  typedef logic [CH_IDX_W-1:0]           ch_idx_t;

endpackage

>>> design/afrpm_if.sv
`timescale 1ns / 1ps
// Request channels of the level meter: the sample input and the level result output.
interface afrpm_sample_if;
  import afrpm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface afrpm_level_if;
  import afrpm_pkg::*;

  logic    valid;
  logic    ready;
  ch_idx_t channel_index;
  level_t  rms_level;
  level_t  peak_level;
  level_t  max_rms_seen;
  level_t  max_peak_seen;
  logic    last_channel;

  modport source (output valid, output channel_index, output rms_level, output peak_level,
                  output max_rms_seen, output max_peak_seen, output last_channel,
                  input ready);
  modport sink (input valid, input channel_index, input rms_level, input peak_level,
                input max_rms_seen, input max_peak_seen, input last_channel,
                output ready);
endinterface

>>> design/audio_frame_rms_peak_meter_core.sv
`timescale 1ns / 1ps
// Per-channel RMS and peak level meter over frames of interleaved audio samples.
// Each sample request steps through the states IDLE, SQ and WB: the accumulator memory is read as
// the sample is taken, the square is formed, and the updated sum of squares and peak are written back.
// At the end of a frame every channel is handled in turn (memory read, a 42-step division
// of the sum by the frame length and a 21-step square root), and the next channel starts only
// once the result request of the current one is taken; no sample is taken during that phase.
// The running maxima start at 0.25 and survive configuration writes, which restart the frame.
module audio_frame_rms_peak_meter_core #(
  parameter int MAX_CHANNELS      = afrpm_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_FRAME_SAMPLES = afrpm_pkg::DEF_MAX_FRAME_SAMPLES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [afrpm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [afrpm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  afrpm_sample_if.sink                     sample_i,
  afrpm_level_if.source                    level_o
);
  import afrpm_pkg::*;

  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ENTRY_W = SUM_BITS + LEVEL_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_WB   = 3'd2;
  localparam logic [2:0] ST_ERD  = 3'd3;
  localparam logic [2:0] ST_ELD  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_SQRT = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]              state_q;
  logic [CC_W-1:0]         chan_count_q;
  logic [LEN_W-1:0]        frame_len_q;
  logic [MAX_CHANNELS-1:0] valid_q;
  logic [CH_W-1:0]         ch_pos_q;
  logic [LEN_W-1:0]        cnt_q;
  logic [CH_W-1:0]         emit_ch_q;
  logic                    out_valid_q;
  logic [LEVEL_W-1:0]      max_rms_q;
  logic [LEVEL_W-1:0]      max_pk_q;

  logic [ENTRY_W-1:0]      mem [MAX_CHANNELS];
  logic [ENTRY_W-1:0]      rdata_q;
  logic                    rvld_q;

  logic [LEVEL_W-1:0]      mag_q;
  logic [CH_W-1:0]         ch_q;
  logic [2*LEVEL_W-1:0]    sq_q;
  logic [LEVEL_W-1:0]      pk_q;
  logic [LEVEL_W-1:0]      rms_q;
  logic [LEN_W-1:0]        div_rem_q;
  logic [SUM_BITS-1:0]     div_quo_q;
  logic [SUM_BITS-1:0]     rad_q;
  logic [SQ_REM_W-1:0]     srem_q;
  logic [ROOT_W-1:0]       root_q;
  logic [STEP_W-1:0]       step_q;

  logic [CC_W-1:0]         eff_chans;
  logic [LEN_W-1:0]        eff_len;
  logic [CH_W-1:0]         cur_ch;
  logic [LEVEL_W-1:0]      mag_in;
  logic                    in_acc;
  logic                    rd_en;
  logic [CH_W-1:0]         rd_addr;
  logic [SUM_BITS-1:0]     old_sum;
  logic [LEVEL_W-1:0]      old_pk;
  logic [SUM_BITS:0]       sum_ext;
  logic [SUM_BITS-1:0]     new_sum;
  logic [LEVEL_W-1:0]      new_pk;
  logic                    last_in_group;
  logic                    emit_last;
  logic [LEN_W:0]          div_shift;
  logic                    div_ge;
  logic [LEN_W-1:0]        div_rem_d;
  logic [SUM_BITS-1:0]     div_quo_d;
  logic [SQ_REM_W-1:0]     sq_shift;
  logic [SQ_REM_W-1:0]     sq_trial;
  logic                    sq_ge;
  logic [SQ_REM_W-1:0]     srem_d;
  logic [ROOT_W-1:0]       root_d;
  logic [LEVEL_W-1:0]      rms_new;

  always_comb begin
    if (chan_count_q == '0) begin
      eff_chans = CC_W'(1);
    end else if (32'(chan_count_q) > MAX_CHANNELS) begin
      eff_chans = CC_W'(MAX_CHANNELS);
    end else begin
      eff_chans = chan_count_q;
    end
    if (frame_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(frame_len_q) > MAX_FRAME_SAMPLES) begin
      eff_len = LEN_W'(MAX_FRAME_SAMPLES);
    end else begin
      eff_len = frame_len_q;
    end
  end

  assign cur_ch  = (32'(ch_pos_q) >= 32'(eff_chans)) ? '0 : ch_pos_q;
  assign mag_in  = sample_i.sample_value[SAMPLE_BITS-1]
                   ? (LEVEL_W'(~sample_i.sample_value) + LEVEL_W'(1))
                   : LEVEL_W'(sample_i.sample_value);
  assign in_acc  = sample_i.valid && sample_i.ready;
  assign rd_en   = in_acc || (state_q == ST_ERD);
  assign rd_addr = (state_q == ST_IDLE) ? cur_ch : emit_ch_q;

  assign old_sum = rvld_q ? rdata_q[ENTRY_W-1:LEVEL_W] : '0;
  assign old_pk  = rvld_q ? rdata_q[LEVEL_W-1:0] : '0;
  assign sum_ext = {1'b0, old_sum} + (SUM_BITS + 1)'(sq_q);
  assign new_sum = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
  assign new_pk  = (mag_q > old_pk) ? mag_q : old_pk;

  assign last_in_group = (32'(ch_q) + 1) >= 32'(eff_chans);
  assign emit_last     = (32'(emit_ch_q) + 1) >= 32'(eff_chans);

  assign div_shift = {div_rem_q, div_quo_q[SUM_BITS-1]};
  assign div_ge    = div_shift >= {1'b0, eff_len};
  assign div_rem_d = div_ge ? LEN_W'(div_shift - {1'b0, eff_len}) : div_shift[LEN_W-1:0];
  assign div_quo_d = {div_quo_q[SUM_BITS-2:0], div_ge};

  assign sq_shift = {srem_q[SQ_REM_W-3:0], rad_q[SUM_BITS-1:SUM_BITS-2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_shift >= sq_trial;
  assign srem_d   = sq_ge ? (sq_shift - sq_trial) : sq_shift;
  assign root_d   = {root_q[ROOT_W-2:0], sq_ge};
  assign rms_new  = root_d[LEVEL_W-1:0];

  assign sample_i.ready        = (state_q == ST_IDLE);
  assign level_o.valid         = out_valid_q;
  assign level_o.channel_index = CH_IDX_W'(emit_ch_q);
  assign level_o.rms_level     = rms_q;
  assign level_o.peak_level    = pk_q;
  assign level_o.max_rms_seen  = max_rms_q;
  assign level_o.max_peak_seen = max_pk_q;
  assign level_o.last_channel  = emit_last;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      rvld_q  <= valid_q[rd_addr];
    end
    if (state_q == ST_WB) begin
      mem[ch_q] <= {new_sum, new_pk};
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mag_q <= mag_in;
          ch_q  <= cur_ch;
        end
      end
      ST_SQ: begin
        sq_q <= mag_q * mag_q;
      end
      ST_ELD: begin
        div_quo_q <= old_sum;
        pk_q      <= old_pk;
        div_rem_q <= '0;
        step_q    <= '0;
      end
      ST_DIV: begin
        div_rem_q <= div_rem_d;
        div_quo_q <= div_quo_d;
        if (32'(step_q) == SUM_BITS - 1) begin
          rad_q  <= div_quo_d;
          srem_q <= '0;
          root_q <= '0;
          step_q <= '0;
        end else begin
          step_q <= step_q + STEP_W'(1);
        end
      end
      ST_SQRT: begin
        srem_q <= srem_d;
        root_q <= root_d;
        rad_q  <= {rad_q[SUM_BITS-3:0], 2'b00};
        step_q <= step_q + STEP_W'(1);
        if (32'(step_q) == ROOT_W - 1) begin
          rms_q <= rms_new;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      chan_count_q <= CC_RESET;
      frame_len_q  <= LEN_RESET;
      valid_q      <= '0;
      ch_pos_q     <= '0;
      cnt_q        <= '0;
      emit_ch_q    <= '0;
      out_valid_q  <= 1'b0;
      max_rms_q    <= START_MAX;
      max_pk_q     <= START_MAX;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CHANNEL_COUNT: begin
            chan_count_q <= cfg_data_i[CC_W-1:0];
            valid_q      <= '0;
            ch_pos_q     <= '0;
            cnt_q        <= '0;
          end
          REG_FRAME_LENGTH: begin
            frame_len_q <= cfg_data_i[LEN_W-1:0];
            valid_q     <= '0;
            ch_pos_q    <= '0;
            cnt_q       <= '0;
          end
          default: begin
          end
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          state_q <= ST_WB;
        end
        ST_WB: begin
          valid_q[ch_q] <= 1'b1;
          if (!last_in_group) begin
            ch_pos_q <= ch_q + CH_W'(1);
            state_q  <= ST_IDLE;
          end else begin
            ch_pos_q <= '0;
            if ((32'(cnt_q) + 1) < 32'(eff_len)) begin
              cnt_q   <= cnt_q + LEN_W'(1);
              state_q <= ST_IDLE;
            end else begin
              cnt_q     <= '0;
              emit_ch_q <= '0;
              state_q   <= ST_ERD;
            end
          end
        end
        ST_ERD: begin
          state_q <= ST_ELD;
        end
        ST_ELD: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (32'(step_q) == SUM_BITS - 1) begin
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (32'(step_q) == ROOT_W - 1) begin
            if (rms_new > max_rms_q) begin
              max_rms_q <= rms_new;
            end
            if (pk_q > max_pk_q) begin
              max_pk_q <= pk_q;
            end
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_valid_q && level_o.ready) begin
            out_valid_q <= 1'b0;
            if (emit_last) begin
              valid_q <= '0;
              state_q <= ST_IDLE;
            end else begin
              emit_ch_q <= emit_ch_q + CH_W'(1);
              state_q   <= ST_ERD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_max_rms_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> max_rms_q >= $past(max_rms_q))
    else $error("running RMS maximum decreased");

  a_max_peak_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> max_pk_q >= $past(max_pk_q))
    else $error("running peak maximum decreased");

  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_o.valid && level_o.ready && level_o.last_channel) |=> valid_q == '0)
    else $error("accumulators not cleared after the last result of a frame");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> div_rem_q < eff_len)
    else $error("division remainder not below the frame length");

  a_result_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(emit_ch_q) < 32'(eff_chans)) && (state_q == ST_OUT))
    else $error("result request for a channel beyond the channel count");
`endif

endmodule
